// ===== hdl/ktf_pkg.sv =====
// Shared types, codes and the pattern parser of the keyed table with ternary filter.
package ktf_pkg;

   localparam int ENTRIES_DEF   = 32;
   localparam int NAME_BITS_DEF = 64;
   localparam int KEY_W         = 64;
   localparam int STAT_W        = 8;
   localparam int OUT_IDX_W     = 5;
   localparam int REQ_IDX_W     = 6;
   localparam int CODE_W        = 3;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_APPEND = 3'd1,
      OP_FIND   = 3'd2,
      OP_REMOVE = 3'd3,
      OP_FILTER = 3'd4
   } ktf_op_type;

   localparam logic [CODE_W-1:0] ST_OK        = 3'd0;
   localparam logic [CODE_W-1:0] ST_FULL      = 3'd1;
   localparam logic [CODE_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [CODE_W-1:0] ST_NO_DATA   = 3'd3;
   localparam logic [CODE_W-1:0] ST_BAD_INDEX = 3'd4;

   localparam logic [7:0] CH_ONE  = 8'h31;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_WILD = 8'h2A;

   typedef struct packed {
      logic             write;
      logic             shift;
      logic             rotate;
   } ktf_cell_ctl_type;

   typedef struct packed {
      logic              bad;
      logic [STAT_W-1:0] ones;
      logic [STAT_W-1:0] care;
   } ktf_pattern_type;

   function automatic ktf_pattern_type ktf_parse(input logic [KEY_W-1:0] text);
      ktf_pattern_type p;
      logic [7:0]      ch;
      p.bad  = 1'b0;
      p.ones = '0;
      p.care = '1;
      for (int i = 0; i < 8; i++) begin
         ch = text[KEY_W-1-8*i -: 8];
         if (ch == CH_ONE) begin
            p.ones[7-i] = 1'b1;
         end else if (ch == CH_WILD) begin
            p.care[7-i] = 1'b0;
         end else if (ch != CH_ZERO) begin
            p.bad = 1'b1;
         end
      end
      return p;
   endfunction

endpackage

// ===== hdl/ktf_cell.sv =====
// One table cell: holds one entry and can load, shift down or rotate from its neighbor.
module ktf_cell #(
   parameter int NAME_BITS = ktf_pkg::NAME_BITS_DEF
) (
   input  logic                      clock,
   input  ktf_pkg::ktf_cell_ctl_type ctl,
   input  logic [NAME_BITS-1:0]      wr_name,
   input  logic [7:0]                wr_status,
   input  logic [NAME_BITS-1:0]      nb_name,
   input  logic [7:0]                nb_status,
   output logic [NAME_BITS-1:0]      name,
   output logic [7:0]                status
);
   import ktf_pkg::*;

   logic [NAME_BITS-1:0] name_ff, name_in;
   logic [STAT_W-1:0]    status_ff, status_in;

   always_comb begin
      name_in   = name_ff;
      status_in = status_ff;
      if (ctl.write) begin
         name_in   = wr_name;
         status_in = wr_status;
      end else if (ctl.shift || ctl.rotate) begin
         name_in   = nb_name;
         status_in = nb_status;
      end
   end

   always_ff @(posedge clock) begin
      name_ff   <= name_in;
      status_ff <= status_in;
   end

   assign name   = name_ff;
   assign status = status_ff;

endmodule

// ===== hdl/keyed_table_with_ternary_filter.sv =====
// Top level of the keyed table with ternary filter: request decode, walk control and result register.
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_type, key_name, new_status, entry_index, filter_text
//   rsp     | out       | rsp_valid/rsp_stall | status_code, found_index, entry_name, entry_status,
//           |           |                     | has_entry, last
// Clear, append, remove and bad requests are handled in the idle state; their result is registered.
// Find and filter rotate the ring of ENTRIES cells once, one entry per cycle while the result
// side does not stall; filter emits one item per match, or one item without entry if none match.
// Reset (synchronous) empties the table; the cells keep no reset value.
// A new item is taken only when the block is idle and the result register is free.
module keyed_table_with_ternary_filter #(
   parameter int ENTRIES   = ktf_pkg::ENTRIES_DEF,
   parameter int NAME_BITS = ktf_pkg::NAME_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_type,
   input  logic [ktf_pkg::KEY_W-1:0]            req_key_name,
   input  logic [ktf_pkg::STAT_W-1:0]           req_new_status,
   input  logic [ktf_pkg::REQ_IDX_W-1:0]        req_entry_index,
   input  logic [ktf_pkg::KEY_W-1:0]            req_filter_text,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ktf_pkg::CODE_W-1:0]           rsp_status_code,
   output logic [ktf_pkg::OUT_IDX_W-1:0]        rsp_found_index,
   output logic [ktf_pkg::KEY_W-1:0]            rsp_entry_name,
   output logic [ktf_pkg::STAT_W-1:0]           rsp_entry_status,
   output logic                                 rsp_has_entry,
   output logic                                 rsp_last
);
   import ktf_pkg::*;

   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int IDX_W = $clog2(ENTRIES);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_WALK = 3'b010,
      S_DONE = 3'b100
   } ktf_state_type;

   ktf_state_type        state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     step_ff, step_in;
   logic                 is_filter_ff, is_filter_in;
   logic [NAME_BITS-1:0] key_ff, key_in;
   logic [STAT_W-1:0]    ones_ff, ones_in, care_ff, care_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     fidx_ff, fidx_in;
   logic                 pend_v_ff, pend_v_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic [NAME_BITS-1:0] pend_name_ff, pend_name_in;
   logic [STAT_W-1:0]    pend_stat_ff, pend_stat_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic [OUT_IDX_W-1:0] oidx_ff, oidx_in;
   logic [KEY_W-1:0]     oname_ff, oname_in;
   logic [STAT_W-1:0]    ostat_ff, ostat_in;
   logic                 ohas_ff, ohas_in;
   logic                 olast_ff, olast_in;

   logic                 out_free, req_fire, out_load, rotate, app_wr, rm_shift, hit;
   ktf_pattern_type      pat;

   logic [NAME_BITS-1:0] cell_name [ENTRIES];
   logic [STAT_W-1:0]    cell_stat [ENTRIES];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign req_fire  = req_valid && !req_stall;
   assign pat       = ktf_parse(req_filter_text);
   assign hit       = (int'(step_ff) < int'(count_ff)) &&
                      (is_filter_ff ? (((cell_stat[0] ^ ones_ff) & care_ff) == '0)
                                    : (cell_name[0] == key_ff));

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      ktf_cell_ctl_type ctl;
      assign ctl.write  = app_wr && (int'(count_ff) == i);
      assign ctl.shift  = rm_shift && (i >= int'(req_entry_index));
      assign ctl.rotate = rotate;
      ktf_cell #(.NAME_BITS(NAME_BITS)) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .wr_name   (req_key_name[NAME_BITS-1:0]),
         .wr_status (req_new_status),
         .nb_name   (cell_name[(i + 1) % ENTRIES]),
         .nb_status (cell_stat[(i + 1) % ENTRIES]),
         .name      (cell_name[i]),
         .status    (cell_stat[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      is_filter_in = is_filter_ff;
      key_in       = key_ff;
      ones_in      = ones_ff;
      care_in      = care_ff;
      found_in     = found_ff;
      fidx_in      = fidx_ff;
      pend_v_in    = pend_v_ff;
      pend_idx_in  = pend_idx_ff;
      pend_name_in = pend_name_ff;
      pend_stat_in = pend_stat_ff;
      rotate       = 1'b0;
      app_wr       = 1'b0;
      rm_shift     = 1'b0;
      out_load     = 1'b0;
      code_in      = ST_OK;
      oidx_in      = '0;
      oname_in     = '0;
      ostat_in     = '0;
      ohas_in      = 1'b0;
      olast_in     = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               out_load = 1'b1;
               case (req_type)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_APPEND: begin
                     if (int'(count_ff) >= ENTRIES) begin
                        code_in = ST_FULL;
                     end else begin
                        app_wr   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_FIND: begin
                     out_load     = 1'b0;
                     is_filter_in = 1'b0;
                     key_in       = req_key_name[NAME_BITS-1:0];
                     found_in     = 1'b0;
                     step_in      = '0;
                     state_in     = S_WALK;
                  end
                  OP_REMOVE: begin
                     if (count_ff == '0) begin
                        code_in = ST_NO_DATA;
                     end else if (int'(req_entry_index) >= int'(count_ff)) begin
                        code_in = ST_BAD_INDEX;
                     end else begin
                        rm_shift = 1'b1;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_FILTER: begin
                     if (pat.bad) begin
                        code_in = ST_NO_DATA;
                     end else begin
                        out_load     = 1'b0;
                        is_filter_in = 1'b1;
                        ones_in      = pat.ones;
                        care_in      = pat.care;
                        pend_v_in    = 1'b0;
                        step_in      = '0;
                        state_in     = S_WALK;
                     end
                  end
                  default: begin
                     code_in = ST_NO_DATA;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (out_free) begin
               rotate  = 1'b1;
               step_in = step_ff + 1'b1;
               if (hit) begin
                  if (is_filter_ff) begin
                     if (pend_v_ff) begin
                        out_load = 1'b1;
                        oidx_in  = OUT_IDX_W'(pend_idx_ff);
                        oname_in = KEY_W'(pend_name_ff);
                        ostat_in = pend_stat_ff;
                        ohas_in  = 1'b1;
                        olast_in = 1'b0;
                     end
                     pend_v_in    = 1'b1;
                     pend_idx_in  = step_ff;
                     pend_name_in = cell_name[0];
                     pend_stat_in = cell_stat[0];
                  end else if (!found_ff) begin
                     found_in = 1'b1;
                     fidx_in  = step_ff;
                  end
               end
               if (int'(step_ff) == ENTRIES - 1) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
               if (is_filter_ff) begin
                  if (pend_v_ff) begin
                     oidx_in  = OUT_IDX_W'(pend_idx_ff);
                     oname_in = KEY_W'(pend_name_ff);
                     ostat_in = pend_stat_ff;
                     ohas_in  = 1'b1;
                  end
               end else if (found_ff) begin
                  oidx_in = OUT_IDX_W'(fidx_ff);
               end else begin
                  code_in = ST_NOT_FOUND;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      is_filter_ff <= is_filter_in;
      key_ff       <= key_in;
      ones_ff      <= ones_in;
      care_ff      <= care_in;
      fidx_ff      <= fidx_in;
      pend_idx_ff  <= pend_idx_in;
      pend_name_ff <= pend_name_in;
      pend_stat_ff <= pend_stat_in;
      if (out_load) begin
         code_ff  <= code_in;
         oidx_ff  <= oidx_in;
         oname_ff <= oname_in;
         ostat_ff <= ostat_in;
         ohas_ff  <= ohas_in;
         olast_ff <= olast_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status_code  = code_ff;
   assign rsp_found_index  = oidx_ff;
   assign rsp_entry_name   = oname_ff;
   assign rsp_entry_status = ostat_ff;
   assign rsp_has_entry    = ohas_ff;
   assign rsp_last         = olast_ff;

endmodule

// ===== hdl/ktf_checker.sv =====
// Port-level assertions for the keyed table with ternary filter, bound to the top level.
module ktf_port_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [ktf_pkg::CODE_W-1:0]    rsp_status_code,
   input logic [ktf_pkg::OUT_IDX_W-1:0] rsp_found_index,
   input logic                          rsp_has_entry,
   input logic                          rsp_last
);
   import ktf_pkg::*;

   // A stalled result stays on the port.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found_index))
      else $error("stalled result dropped or changed");

   // No new item is taken while a filter still has results to deliver.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("item accepted in the middle of a filter burst");

   // Only a filtered entry can be followed by more results.
   a_last_plain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_entry |-> rsp_last)
      else $error("result without entry is not the last one");

   // An error result is always single and carries no entry.
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status_code != ST_OK |-> rsp_last && !rsp_has_entry)
      else $error("error result carries an entry or is not the last one");

endmodule

bind keyed_table_with_ternary_filter ktf_port_checker u_ktf_checker (.*);

// ===== bench/ktf_checker.sv =====
// Checker for the keyed table: predicts each request's results and compares them in order.
module ktf_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [2:0]                     req_type,
   input  logic [ktf_pkg::KEY_W-1:0]      req_key_name,
   input  logic [ktf_pkg::STAT_W-1:0]     req_new_status,
   input  logic [ktf_pkg::REQ_IDX_W-1:0]  req_entry_index,
   input  logic [ktf_pkg::KEY_W-1:0]      req_filter_text,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [ktf_pkg::CODE_W-1:0]     rsp_status_code,
   input  logic [ktf_pkg::OUT_IDX_W-1:0]  rsp_found_index,
   input  logic [ktf_pkg::KEY_W-1:0]      rsp_entry_name,
   input  logic [ktf_pkg::STAT_W-1:0]     rsp_entry_status,
   input  logic                           rsp_has_entry,
   input  logic                           rsp_last,
   output int                             error_count,
   output int                             pending_count,
   output int                             request_count,
   output int                             result_count,
   output int                             match_count,
   output int                             full_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ktf_pkg::*;

   localparam logic [KEY_W-1:0] NAME_MASK = {KEY_W{1'b1}} >> (KEY_W - NAME_BITS_DEF);

   typedef struct {
      logic [CODE_W-1:0]    code;
      logic [OUT_IDX_W-1:0] index;
      logic [KEY_W-1:0]     name;
      logic [STAT_W-1:0]    stat;
      logic                 has;
      logic                 last;
   } table_result_type;

   table_result_type  expected_results[$];
   int                tbl_count;
   logic [KEY_W-1:0]  tbl_name[ENTRIES_DEF];
   logic [STAT_W-1:0] tbl_status[ENTRIES_DEF];
   int                errs;
   int                n_req;
   int                n_rsp;
   int                n_match;
   int                n_full;

   function automatic table_result_type make_result(input logic [CODE_W-1:0] code,
                                                    input logic [OUT_IDX_W-1:0] index,
                                                    input logic [KEY_W-1:0] name,
                                                    input logic [STAT_W-1:0] stat,
                                                    input logic has,
                                                    input logic last);
      table_result_type r;
      r.code = code;
      r.index = index;
      r.name = name;
      r.stat = stat;
      r.has = has;
      r.last = last;
      return r;
   endfunction

   task automatic predict_request(input logic [2:0] op, input logic [KEY_W-1:0] key,
                                  input logic [STAT_W-1:0] stat,
                                  input logic [REQ_IDX_W-1:0] idx,
                                  input logic [KEY_W-1:0] text);
      logic [KEY_W-1:0] name;
      logic [7:0]       ch;
      logic             bad;
      logic             hit;
      int               found;
      int               hits;
      table_result_type tail;
      name = key & NAME_MASK;
      bad = 1'b0;
      found = -1;
      hits = 0;
      case (op)
         OP_CLEAR: begin
            tbl_count = 0;
            expected_results.push_back(make_result(ST_OK, '0, '0, '0, 1'b0, 1'b1));
         end
         OP_APPEND: begin
            if (tbl_count >= ENTRIES_DEF) begin
               n_full++;
               expected_results.push_back(make_result(ST_FULL, '0, '0, '0, 1'b0, 1'b1));
            end else begin
               tbl_name[tbl_count] = name;
               tbl_status[tbl_count] = stat;
               tbl_count++;
               expected_results.push_back(make_result(ST_OK, '0, '0, '0, 1'b0, 1'b1));
            end
         end
         OP_FIND: begin
            for (int e = 0; e < tbl_count; e++) begin
               if (found < 0 && tbl_name[e] == name) begin
                  found = e;
               end
            end
            if (found < 0) begin
               expected_results.push_back(make_result(ST_NOT_FOUND, '0, '0, '0, 1'b0, 1'b1));
            end else begin
               expected_results.push_back(make_result(ST_OK, OUT_IDX_W'(found), '0, '0,
                                                      1'b0, 1'b1));
            end
         end
         OP_REMOVE: begin
            if (tbl_count == 0) begin
               expected_results.push_back(make_result(ST_NO_DATA, '0, '0, '0, 1'b0, 1'b1));
            end else if (int'(idx) >= tbl_count) begin
               expected_results.push_back(make_result(ST_BAD_INDEX, '0, '0, '0, 1'b0, 1'b1));
            end else begin
               for (int e = int'(idx); e + 1 < tbl_count; e++) begin
                  tbl_name[e] = tbl_name[e + 1];
                  tbl_status[e] = tbl_status[e + 1];
               end
               tbl_count--;
               expected_results.push_back(make_result(ST_OK, '0, '0, '0, 1'b0, 1'b1));
            end
         end
         OP_FILTER: begin
            for (int c = 0; c < 8; c++) begin
               ch = text[KEY_W-1-8*c -: 8];
               if (ch != CH_ONE && ch != CH_ZERO && ch != CH_WILD) begin
                  bad = 1'b1;
               end
            end
            if (bad) begin
               expected_results.push_back(make_result(ST_NO_DATA, '0, '0, '0, 1'b0, 1'b1));
            end else begin
               for (int e = 0; e < tbl_count; e++) begin
                  hit = 1'b1;
                  for (int c = 0; c < 8; c++) begin
                     ch = text[KEY_W-1-8*c -: 8];
                     if ((ch == CH_ONE && !tbl_status[e][7-c]) ||
                         (ch == CH_ZERO && tbl_status[e][7-c])) begin
                        hit = 1'b0;
                     end
                  end
                  if (hit) begin
                     expected_results.push_back(make_result(ST_OK, OUT_IDX_W'(e), tbl_name[e],
                                                            tbl_status[e], 1'b1, 1'b0));
                     hits++;
                  end
               end
               if (hits == 0) begin
                  expected_results.push_back(make_result(ST_OK, '0, '0, '0, 1'b0, 1'b1));
               end else begin
                  tail = expected_results.pop_back();
                  tail.last = 1'b1;
                  expected_results.push_back(tail);
               end
            end
         end
         default: begin
            expected_results.push_back(make_result(ST_NO_DATA, '0, '0, '0, 1'b0, 1'b1));
         end
      endcase
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         errs++;
         $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      table_result_type want;
      if (reset) begin
         tbl_count = 0;
         expected_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            n_req++;
            predict_request(req_type, req_key_name, req_new_status, req_entry_index,
                            req_filter_text);
         end
         if (rsp_valid && !rsp_stall) begin
            n_rsp++;
            if (rsp_has_entry === 1'b1) begin
               n_match++;
            end
            if (expected_results.size() == 0) begin
               errs++;
               $display("%0t ns: unexpected result, expected none, got code %0d index %0d",
                        $time, rsp_status_code, rsp_found_index);
            end else begin
               want = expected_results.pop_front();
               check_field("status_code", 64'(want.code), 64'(rsp_status_code));
               check_field("found_index", 64'(want.index), 64'(rsp_found_index));
               check_field("entry_name", want.name, rsp_entry_name);
               check_field("entry_status", 64'(want.stat), 64'(rsp_entry_status));
               check_field("has_entry", 64'(want.has), 64'(rsp_has_entry));
               check_field("last", 64'(want.last), 64'(rsp_last));
            end
         end
      end
      error_count <= errs;
      pending_count <= expected_results.size();
      request_count <= n_req;
      result_count <= n_rsp;
      match_count <= n_match;
      full_count <= n_full;
   end

endmodule

// ===== bench/keyed_table_with_ternary_filter_tb.sv =====
// Top of the keyed table testbench: clock, reset, request and stall stimulus, watchdog and verdict.
module keyed_table_with_ternary_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ktf_pkg::*;

   localparam logic [2:0] OP_UNKNOWN_LO = 3'd5;
   localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;
   localparam int         IDLE_LIMIT    = 5000;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [2:0]            req_type = OP_CLEAR;
   logic [KEY_W-1:0]      req_key_name = '0;
   logic [STAT_W-1:0]     req_new_status = '0;
   logic [REQ_IDX_W-1:0]  req_entry_index = '0;
   logic [KEY_W-1:0]      req_filter_text = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CODE_W-1:0]     rsp_status_code;
   logic [OUT_IDX_W-1:0]  rsp_found_index;
   logic [KEY_W-1:0]      rsp_entry_name;
   logic [STAT_W-1:0]     rsp_entry_status;
   logic                  rsp_has_entry;
   logic                  rsp_last;

   int                    error_count;
   int                    pending_count;
   int                    request_count;
   int                    result_count;
   int                    match_count;
   int                    full_count;
   int                    idle_cycles = 0;
   logic [KEY_W-1:0]      name_pool[8];

   keyed_table_with_ternary_filter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_key_name     (req_key_name),
      .req_new_status   (req_new_status),
      .req_entry_index  (req_entry_index),
      .req_filter_text  (req_filter_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status_code  (rsp_status_code),
      .rsp_found_index  (rsp_found_index),
      .rsp_entry_name   (rsp_entry_name),
      .rsp_entry_status (rsp_entry_status),
      .rsp_has_entry    (rsp_has_entry),
      .rsp_last         (rsp_last)
   );

   ktf_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_key_name     (req_key_name),
      .req_new_status   (req_new_status),
      .req_entry_index  (req_entry_index),
      .req_filter_text  (req_filter_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status_code  (rsp_status_code),
      .rsp_found_index  (rsp_found_index),
      .rsp_entry_name   (rsp_entry_name),
      .rsp_entry_status (rsp_entry_status),
      .rsp_has_entry    (rsp_has_entry),
      .rsp_last         (rsp_last),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .request_count    (request_count),
      .result_count     (result_count),
      .match_count      (match_count),
      .full_count       (full_count)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 9) < 7) begin
         return name_pool[$urandom_range(0, 7)];
      end
      return {$urandom, $urandom};
   endfunction

   function automatic logic [KEY_W-1:0] pick_pattern();
      logic [KEY_W-1:0] text;
      int               r;
      for (int c = 0; c < 8; c++) begin
         r = $urandom_range(0, 3);
         text[KEY_W-1-8*c -: 8] = (r == 0) ? CH_ONE : (r == 1) ? CH_ZERO : CH_WILD;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         text = "********";
      end else if (r < 15) begin
         text[KEY_W-1-8*$urandom_range(0, 7) -: 8] = 8'($urandom_range(0, 255));
      end else if (r < 18) begin
         text = {$urandom, $urandom};
      end
      return text;
   endfunction

   task automatic send_item(input logic [2:0] op, input logic [KEY_W-1:0] key,
                            input logic [STAT_W-1:0] stat,
                            input logic [REQ_IDX_W-1:0] idx,
                            input logic [KEY_W-1:0] text);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_key_name <= key;
      req_new_status <= stat;
      req_entry_index <= idx;
      req_filter_text <= text;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   task automatic send_random(input int append_pct, input int remove_pct);
      int               r;
      logic [REQ_IDX_W-1:0] idx;
      r = $urandom_range(0, 99);
      idx = ($urandom_range(0, 1) == 0) ? REQ_IDX_W'($urandom_range(0, 7))
                                        : REQ_IDX_W'($urandom_range(0, 63));
      if (r < 1) begin
         send_item(OP_CLEAR, pick_key(), 8'($urandom), idx, pick_pattern());
      end else if (r < 3) begin
         send_item(3'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI)), pick_key(),
                   8'($urandom), idx, pick_pattern());
      end else if (r < 3 + append_pct) begin
         send_item(OP_APPEND, pick_key(), 8'($urandom), idx, pick_pattern());
      end else if (r < 3 + append_pct + remove_pct) begin
         send_item(OP_REMOVE, pick_key(), 8'($urandom), idx, pick_pattern());
      end else if ($urandom_range(0, 1) == 0) begin
         send_item(OP_FIND, pick_key(), 8'($urandom), idx, pick_pattern());
      end else begin
         send_item(OP_FILTER, pick_key(), 8'($urandom), idx, pick_pattern());
      end
   endtask

   initial begin
      int run;
      wait (!reset);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
         rsp_stall <= 1'b0;
         repeat (run) @(posedge clock);
         run = gap_len();
         if (run > 0) begin
            rsp_stall <= 1'b1;
            repeat (run) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int append_pct;
      int remove_pct;
      name_pool[0] = '1;
      name_pool[1] = '0;
      for (int k = 2; k < 8; k++) begin
         name_pool[k] = {$urandom, $urandom};
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_CLEAR, '0, '0, '0, '0);
      send_item(OP_REMOVE, '0, '0, '0, '0);
      send_item(OP_FIND, '0, '0, '0, '0);
      send_item(OP_FILTER, '0, '0, '0, "********");
      send_item(OP_APPEND, '1, 8'hFF, '1, '1);
      send_item(OP_APPEND, '0, 8'h00, '0, '0);
      send_item(OP_APPEND, name_pool[2], 8'hA5, '0, '0);
      send_item(OP_APPEND, '1, 8'h5A, '0, '0);
      send_item(OP_FIND, '1, '0, '0, '0);
      send_item(OP_FIND, name_pool[3], '0, '0, '0);
      send_item(OP_FILTER, '0, '0, '0, "********");
      send_item(OP_FILTER, '0, '0, '0, "11111111");
      send_item(OP_FILTER, '0, '0, '0, "10100101");
      send_item(OP_FILTER, '0, '0, '0, {"1100000", 8'h00});
      send_item(OP_FILTER, '0, '0, '0, {8'hFF, "*******"});
      send_item(OP_REMOVE, '0, '0, '1, '0);
      send_item(OP_REMOVE, '0, '0, 6'd4, '0);
      send_item(OP_REMOVE, '0, '0, 6'd3, '0);
      send_item(OP_REMOVE, '0, '0, '0, '0);
      send_item(OP_UNKNOWN_LO, '1, '1, '1, '1);
      send_item(OP_UNKNOWN_HI, '0, '0, '0, '0);
      send_item(OP_FIND, '0, '0, '0, '0);
      send_item(OP_FILTER, '0, '0, '0, "00000001");
      send_item(OP_CLEAR, '1, '1, '1, '1);

      for (int round = 0; round < 4; round++) begin
         case (round)
            0: begin
               append_pct = 70;
               remove_pct = 5;
            end
            1: begin
               append_pct = 35;
               remove_pct = 25;
            end
            2: begin
               append_pct = 20;
               remove_pct = 45;
            end
            default: begin
               append_pct = 55;
               remove_pct = 10;
            end
         endcase
         for (int k = 0; k < 90; k++) begin
            send_random(append_pct, remove_pct);
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (ENTRIES_DEF + 8) @(posedge clock);

      $display("Covered %0d requests and %0d results, %0d of them filtered entries.",
               request_count, result_count, match_count);
      $display("Appends refused on a full table: %0d.", full_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/ktf_pkg.sv
hdl/ktf_cell.sv
hdl/keyed_table_with_ternary_filter.sv
hdl/ktf_checker.sv
bench/ktf_checker.sv
bench/keyed_table_with_ternary_filter_tb.sv
